FILE: rtl/ipec_pkg.sv
package ipec_pkg;

    localparam int TABLE_SLOTS = 8;
    localparam int V4_RES_COUNT = 17;

    localparam logic [1:0] OP_CLASSIFY_V4 = 2'd0;
    localparam logic [1:0] OP_CLASSIFY_V6 = 2'd1;
    localparam logic [1:0] OP_WRITE_V4 = 2'd2;
    localparam logic [1:0] OP_WRITE_V6 = 2'd3;

    localparam logic [2:0] VERDICT_EXTERNAL = 3'd0;
    localparam logic [2:0] VERDICT_RES_V4 = 3'd1;
    localparam logic [2:0] VERDICT_LOCAL_V4 = 3'd2;
    localparam logic [2:0] VERDICT_LOCAL_V6 = 3'd3;
    localparam logic [2:0] VERDICT_RES_V6 = 3'd4;

    localparam logic [31:0] V4_RES_NET [V4_RES_COUNT] = '{
        32'h00000000, 32'h0a000000, 32'h64400000, 32'h7f000000,
        32'ha9fe0000, 32'hac100000, 32'hc0000000, 32'hc0000200,
        32'hc0586300, 32'hc0a80000, 32'hc6120000, 32'hc6336400,
        32'hcb007100, 32'he0000000, 32'he9fc0000, 32'hf0000000,
        32'hffffffff
    };

    localparam logic [31:0] V4_RES_MASK [V4_RES_COUNT] = '{
        32'hff000000, 32'hff000000, 32'hffc00000, 32'hff000000,
        32'hffff0000, 32'hfff00000, 32'hffffff00, 32'hffffff00,
        32'hffffff00, 32'hffff0000, 32'hfffe0000, 32'hffffff00,
        32'hffffff00, 32'hf0000000, 32'hffff0000, 32'hf0000000,
        32'hffffffff
    };

    localparam logic [31:0] MAP_V4_TOP = 32'h0000ffff;
    localparam logic [31:0] MAP_SIIT_TOP = 32'hffff0000;
    localparam logic [63:0] MAP_NAT64_HI = 64'h0064ff9b00000000;

    localparam logic [63:0] ULA_MASK = 64'hfe00000000000000;
    localparam logic [63:0] ULA_NET = 64'hfc00000000000000;
    localparam logic [63:0] SITE_MASK = 64'hffc0000000000000;
    localparam logic [63:0] SITE_NET = 64'hfec0000000000000;
    localparam logic [63:0] LINK_NET = 64'hfe80000000000000;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [63:0] mask_hi;
        logic [63:0] mask_lo;
        logic [2:0]  entry_index;
        logic        entry_valid;
    } t_in_item;

    typedef struct packed {
        logic       is_external;
        logic [2:0] verdict;
        logic       was_mapped;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic write;
        logic match;
        logic resolve;
    } t_cmd;

    typedef struct packed {
        logic in_is_write;
    } t_status;

endpackage

FILE: rtl/ipec_ctrl.sv
module ipec_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  ipec_pkg::t_status i_status,
    output ipec_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_MATCH   = 3'b010,
        S_RESOLVE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_idle;

    assign w_idle = (r_state == S_IDLE);
    assign o_busy = !w_idle;

    always_comb begin
        o_cmd.load    = i_start && w_idle && !i_status.in_is_write;
        o_cmd.write   = i_start && w_idle && i_status.in_is_write;
        o_cmd.match   = (r_state == S_MATCH);
        o_cmd.resolve = (r_state == S_RESOLVE);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH:   n_state = S_RESOLVE;
            S_RESOLVE: n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/ipec_datapath.sv
module ipec_datapath #(
    parameter int V4_ENTRIES = 8,
    parameter int V6_ENTRIES = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ipec_pkg::t_in_item  i_item,
    input  ipec_pkg::t_cmd      i_cmd,
    output ipec_pkg::t_status   o_status,
    output logic                o_done,
    output ipec_pkg::t_out_item o_result
);

    // only slots reachable by entry_index are stored
    localparam int V4_SLOTS = (V4_ENTRIES < ipec_pkg::TABLE_SLOTS) ?
                              V4_ENTRIES : ipec_pkg::TABLE_SLOTS;
    localparam int V6_SLOTS = (V6_ENTRIES < ipec_pkg::TABLE_SLOTS) ?
                              V6_ENTRIES : ipec_pkg::TABLE_SLOTS;

    logic [31:0] r_v4_net  [V4_SLOTS];
    logic [31:0] r_v4_mask [V4_SLOTS];
    logic [V4_SLOTS-1:0] r_v4_on;
    logic [63:0] r_v6_net_hi  [V6_SLOTS];
    logic [63:0] r_v6_net_lo  [V6_SLOTS];
    logic [63:0] r_v6_mask_hi [V6_SLOTS];
    logic [63:0] r_v6_mask_lo [V6_SLOTS];
    logic [V6_SLOTS-1:0] r_v6_on;

    logic        r_is_v6;
    logic [63:0] r_hi;
    logic [63:0] r_lo;

    logic [ipec_pkg::V4_RES_COUNT-1:0] r_v4_res_hit;
    logic [V4_SLOTS-1:0] r_v4_tab_hit;
    logic [V6_SLOTS-1:0] r_v6_tab_hit;
    logic        r_v6_res_hit;
    logic        r_mapped;
    logic        r_v6_path;

    logic                r_done;
    ipec_pkg::t_out_item r_result;

    logic [31:0] w_v4a;
    logic [31:0] w_top;
    logic        w_carries;
    logic        w_v6_res;
    logic [ipec_pkg::V4_RES_COUNT-1:0] w_v4_res_hit;
    logic [V4_SLOTS-1:0] w_v4_tab_hit;
    logic [V6_SLOTS-1:0] w_v6_tab_hit;
    logic [2:0]  w_verdict;

    assign o_status.in_is_write = (i_item.op == ipec_pkg::OP_WRITE_V4) ||
                                  (i_item.op == ipec_pkg::OP_WRITE_V6);

    // table writes
    for (genvar g = 0; g < V4_SLOTS; g++) begin : g_v4
        logic w_sel;
        assign w_sel = i_cmd.write && (i_item.op == ipec_pkg::OP_WRITE_V4) &&
                       (i_item.entry_index == 3'(g));
        always_ff @(posedge i_clk) begin
            if (w_sel) begin
                r_v4_net[g]  <= i_item.addr_lo[31:0];
                r_v4_mask[g] <= i_item.mask_lo[31:0];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v4_on[g] <= 1'b0;
            end else if (w_sel) begin
                r_v4_on[g] <= i_item.entry_valid;
            end
        end
        assign w_v4_tab_hit[g] = r_v4_on[g] &&
            ((w_v4a & r_v4_mask[g]) == (r_v4_net[g] & r_v4_mask[g]));
    end

    for (genvar g = 0; g < V6_SLOTS; g++) begin : g_v6
        logic w_sel;
        assign w_sel = i_cmd.write && (i_item.op == ipec_pkg::OP_WRITE_V6) &&
                       (i_item.entry_index == 3'(g));
        always_ff @(posedge i_clk) begin
            if (w_sel) begin
                r_v6_net_hi[g]  <= i_item.addr_hi;
                r_v6_net_lo[g]  <= i_item.addr_lo;
                r_v6_mask_hi[g] <= i_item.mask_hi;
                r_v6_mask_lo[g] <= i_item.mask_lo;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v6_on[g] <= 1'b0;
            end else if (w_sel) begin
                r_v6_on[g] <= i_item.entry_valid;
            end
        end
        assign w_v6_tab_hit[g] = r_v6_on[g] &&
            ((r_hi & r_v6_mask_hi[g]) == (r_v6_net_hi[g] & r_v6_mask_hi[g])) &&
            ((r_lo & r_v6_mask_lo[g]) == (r_v6_net_lo[g] & r_v6_mask_lo[g]));
    end

    // fixed ranges
    assign w_v4a = r_lo[31:0];
    assign w_top = r_lo[63:32];

    for (genvar k = 0; k < ipec_pkg::V4_RES_COUNT; k++) begin : g_res
        assign w_v4_res_hit[k] =
            ((w_v4a & ipec_pkg::V4_RES_MASK[k]) == ipec_pkg::V4_RES_NET[k]);
    end

    assign w_carries = ((r_hi == 64'd0) &&
                        ((w_top == ipec_pkg::MAP_V4_TOP) ||
                         (w_top == ipec_pkg::MAP_SIIT_TOP))) ||
                       ((r_hi == ipec_pkg::MAP_NAT64_HI) && (w_top == 32'd0));

    assign w_v6_res = ((r_hi & ipec_pkg::ULA_MASK) == ipec_pkg::ULA_NET) ||
                      ((r_hi & ipec_pkg::SITE_MASK) == ipec_pkg::SITE_NET) ||
                      ((r_hi & ipec_pkg::SITE_MASK) == ipec_pkg::LINK_NET) ||
                      ((r_hi == 64'd0) && (r_lo == 64'd1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_v6 <= (i_item.op == ipec_pkg::OP_CLASSIFY_V6);
            r_hi    <= i_item.addr_hi;
            r_lo    <= i_item.addr_lo;
        end
        if (i_cmd.match) begin
            r_v4_res_hit <= w_v4_res_hit;
            r_v4_tab_hit <= w_v4_tab_hit;
            r_v6_tab_hit <= w_v6_tab_hit;
            r_v6_res_hit <= w_v6_res;
            r_mapped     <= r_is_v6 && w_carries;
            r_v6_path    <= r_is_v6 && !w_carries;
        end
        if (i_cmd.resolve) begin
            r_result.is_external <= (w_verdict == ipec_pkg::VERDICT_EXTERNAL);
            r_result.verdict     <= w_verdict;
            r_result.was_mapped  <= r_mapped;
        end
    end

    // local table wins over fixed ranges for native v6
    always_comb begin
        priority if (!r_v6_path && (|r_v4_res_hit)) begin
            w_verdict = ipec_pkg::VERDICT_RES_V4;
        end else if (!r_v6_path && (|r_v4_tab_hit)) begin
            w_verdict = ipec_pkg::VERDICT_LOCAL_V4;
        end else if (r_v6_path && (|r_v6_tab_hit)) begin
            w_verdict = ipec_pkg::VERDICT_LOCAL_V6;
        end else if (r_v6_path && r_v6_res_hit) begin
            w_verdict = ipec_pkg::VERDICT_RES_V6;
        end else begin
            w_verdict = ipec_pkg::VERDICT_EXTERNAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.resolve;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

FILE: rtl/ip_address_external_classifier.sv
// IPv4 / IPv6 external address classifier.
// Input channel: i_item is taken at a rising edge where i_start is high and
// o_busy is low. op selects classify v4, classify v6, write v4 entry or
// write v6 entry.
// Writes update the local network table at the accepting edge, produce no
// result and leave o_busy low, so a new transaction can follow at once.
// A classify transaction raises o_busy for a match step, with the masked
// compares against fixed ranges and table entries (all in parallel), and a
// resolve step that turns the priority into a verdict.
// The result appears on o_result with o_done high for exactly one cycle,
// after the resolve step, and is taken at the edge that ends that cycle;
// o_busy drops in that same cycle so the next transaction may be
// accepted at the edge that ends the result cycle.
// Classifies do not overlap; writes are taken one per cycle while o_busy is low.
// The receiver cannot stall; each result is taken in its strobe cycle.
// Reset (synchronous, active low) returns the controller to idle, drops
// o_done and disables all table entries; entry contents are kept.
module ip_address_external_classifier #(
    parameter int V4_ENTRIES = 8,
    parameter int V6_ENTRIES = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ipec_pkg::t_in_item  i_item,
    output logic                o_busy,
    output logic                o_done,
    output ipec_pkg::t_out_item o_result
);

    ipec_pkg::t_cmd    w_cmd;
    ipec_pkg::t_status w_status;

    ipec_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (o_busy)
    );

    ipec_datapath #(
        .V4_ENTRIES (V4_ENTRIES),
        .V6_ENTRIES (V6_ENTRIES)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

FILE: rtl/ipec_checker.sv
module ipec_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input ipec_pkg::t_in_item  i_item,
    input logic                o_busy,
    input logic                o_done,
    input ipec_pkg::t_out_item o_result
);

    logic w_classify_acc;

    assign w_classify_acc = i_start && !o_busy &&
                            ((i_item.op == ipec_pkg::OP_CLASSIFY_V4) ||
                             (i_item.op == ipec_pkg::OP_CLASSIFY_V6));

    a_classify_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_classify_acc |=> o_busy)
        else $error("busy not raised after classify transaction");

    a_classify_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_classify_acc |-> ##3 o_done)
        else $error("classify result missing");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_external_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.is_external ==
                    (o_result.verdict == ipec_pkg::VERDICT_EXTERNAL)))
        else $error("is_external disagrees with verdict");

    a_mapped_v4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.was_mapped) |->
            ((o_result.verdict == ipec_pkg::VERDICT_EXTERNAL) ||
             (o_result.verdict == ipec_pkg::VERDICT_RES_V4) ||
             (o_result.verdict == ipec_pkg::VERDICT_LOCAL_V4)))
        else $error("mapped address given a v6 verdict");

endmodule

bind ip_address_external_classifier ipec_checker u_ipec_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .i_item   (i_item),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);
